// ----- sv/bpms_pkg.sv -----
`timescale 1ns / 1ps

package bpms_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_SHORT_MAX  = 2'd1;
    localparam logic [1:0] CFG_LONG_MIN   = 2'd2;
    localparam logic [1:0] CFG_MAX_MODE   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration and of the mode.
    localparam logic [15:0] DEBOUNCE_RESET  = 16'd50;
    localparam logic [15:0] SHORT_MAX_RESET = 16'd500;
    localparam logic [15:0] LONG_MIN_RESET  = 16'd1000;
    localparam logic [3:0]  MAX_MODE_RESET  = 4'd8;
    localparam logic [3:0]  MODE_RESET      = 4'd1;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    localparam int NUM_BUTTONS = 2;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        level_one;
        logic        level_two;
        logic        start_select;
        logic [3:0]  current_mode;
    } t_in;

    typedef struct packed {
        logic        selecting;
        logic [3:0]  selected_mode;
        logic        confirmed;
        logic        held_one;
        logic        held_two;
        logic        released_two;
        logic [31:0] duration_two;
    } t_out;

    // Poll after classification: time already reduced to the counter width,
    // pin levels turned into active-high press requests.
    typedef struct packed {
        logic [31:0]            now_ms;
        logic [NUM_BUTTONS-1:0] press_req;
        logic                   start_select;
        logic [3:0]             load_mode;
    } t_poll;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] short_press_max_ms;
        logic [15:0] long_press_min_ms;
        logic [3:0]  max_mode;
    } t_cfg;

endpackage

// ----- sv/bpms_front.sv -----
`timescale 1ns / 1ps

module bpms_front #(
    parameter int TIME_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bpms_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output bpms_pkg::t_poll o_poll
);
    import bpms_pkg::*;

    localparam logic [31:0] TIME_MASK = 32'((64'd1 << TIME_BITS) - 64'd1);

    logic  r_valid;
    t_poll r_poll;
    t_poll n_poll;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_poll  = r_poll;

    always_comb begin
        n_poll.now_ms       = i_item.now_ms & TIME_MASK;
        n_poll.press_req    = {!i_item.level_two, !i_item.level_one};
        n_poll.start_select = i_item.start_select;
        n_poll.load_mode    = i_item.current_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_poll <= n_poll;
        end
    end

endmodule

// ----- sv/bpms_queue.sv -----
`timescale 1ns / 1ps

module bpms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bpms_pkg::t_poll i_poll,
    output logic            o_valid,
    input  logic            i_ready,
    output bpms_pkg::t_poll o_poll
);
    import bpms_pkg::*;

    t_poll                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   push;
    logic                   pop;

    assign o_ready = (r_count != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_poll  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_poll;
        end
    end

endmodule

// ----- sv/bpms_back.sv -----
`timescale 1ns / 1ps

module bpms_back #(
    parameter int TIME_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpms_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  bpms_pkg::t_poll i_poll,
    output logic            o_valid,
    input  logic            i_ready,
    output bpms_pkg::t_out  o_item
);
    import bpms_pkg::*;

    logic [NUM_BUTTONS-1:0] r_pressed;
    logic [NUM_BUTTONS-1:0] r_released;
    logic [TIME_BITS-1:0]   r_start [NUM_BUTTONS];
    logic [TIME_BITS-1:0]   r_dur   [NUM_BUTTONS];
    logic [3:0]             r_mode;
    logic                   r_select;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [NUM_BUTTONS-1:0] n_pressed;
    logic [NUM_BUTTONS-1:0] n_released;
    logic [TIME_BITS-1:0]   n_start [NUM_BUTTONS];
    logic [TIME_BITS-1:0]   n_dur   [NUM_BUTTONS];
    logic [3:0]             n_mode;
    logic                   n_select;
    logic                   n_confirmed;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   since [NUM_BUTTONS];
    logic                   pop;

    assign o_ready = !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign now_t   = i_poll.now_ms[TIME_BITS-1:0];

    always_comb begin
        n_pressed   = r_pressed;
        n_released  = r_released;
        n_mode      = r_mode;
        n_select    = r_select;
        n_confirmed = 1'b0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_start[b] = r_start[b];
            n_dur[b]   = r_dur[b];
            since[b]   = now_t - r_start[b];
        end

        // A new selection reloads the mode and drops pending releases.
        if (i_poll.start_select) begin
            n_select   = 1'b1;
            n_mode     = i_poll.load_mode;
            n_released = '0;
        end

        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (i_poll.press_req[b] && !r_pressed[b]) begin
                if (since[b] > TIME_BITS'(i_cfg.debounce_ms)) begin
                    n_pressed[b]  = 1'b1;
                    n_released[b] = 1'b0;
                    n_start[b]    = now_t;
                end
            end else if (!i_poll.press_req[b] && r_pressed[b]) begin
                n_dur[b]      = since[b];
                n_pressed[b]  = 1'b0;
                n_released[b] = 1'b1;
            end
        end

        // Short press is tested first and consumes the release, so a
        // duration that is both short and long only advances the mode.
        if (n_select) begin
            if (n_released[0] && (n_dur[0] < TIME_BITS'(i_cfg.short_press_max_ms))) begin
                n_mode        = (n_mode >= i_cfg.max_mode) ? 4'd0 : n_mode + 4'd1;
                n_released[0] = 1'b0;
            end
            if (n_released[0] && (n_dur[0] >= TIME_BITS'(i_cfg.long_press_min_ms))) begin
                n_released[0] = 1'b0;
                n_select      = 1'b0;
                n_confirmed   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed   <= '0;
            r_released  <= '0;
            r_mode      <= MODE_RESET;
            r_select    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_start[b] <= '0;
                r_dur[b]   <= '0;
            end
        end else begin
            if (pop) begin
                r_pressed  <= n_pressed;
                r_released <= n_released;
                r_mode     <= n_mode;
                r_select   <= n_select;
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    r_start[b] <= n_start[b];
                    r_dur[b]   <= n_dur[b];
                end
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.selecting     <= n_select;
            r_out.selected_mode <= n_mode;
            r_out.confirmed     <= n_confirmed;
            r_out.held_one      <= n_pressed[0];
            r_out.held_two      <= n_pressed[1];
            r_out.released_two  <= n_released[1];
            r_out.duration_two  <= 32'(n_dur[1]);
        end
    end

endmodule

// ----- sv/button_press_mode_selector_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ---------------------------------
// in        input      i_in_valid / o_in_ready     i_in  (bpms_pkg::t_in, one poll)
// out       output     o_out_valid / i_out_ready   o_out (bpms_pkg::t_out, one result)
// cfg       input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One result item leaves for every poll item, and a new poll can be taken every cycle
// while the output is not stalled. A result passes through the front register, the
// two-entry queue and the output register of the back end, in that order.
// The rate is set by the back end, whose state update handles one poll per cycle while
// its output is not stalled. Reset is synchronous and active low; it empties every
// stage and loads the default configuration. A stalled output holds its result, the
// back end stops, and the queue and front register absorb up to three more polls
// before o_in_ready falls.

module button_press_mode_selector_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  bpms_pkg::t_in                          i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output bpms_pkg::t_out                         o_out,
    input  logic                                   i_cfg_we,
    input  logic [bpms_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [bpms_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import bpms_pkg::*;

    // Configuration registers. The user must change them only while the block is idle; the
    // block does not enforce this, and the back end reads them directly without any shadow copy.
    t_cfg  r_cfg;

    logic  front_valid;
    logic  front_ready;
    t_poll front_poll;
    logic  queue_valid;
    logic  queue_ready;
    t_poll queue_poll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= DEBOUNCE_RESET;
            r_cfg.short_press_max_ms <= SHORT_MAX_RESET;
            r_cfg.long_press_min_ms  <= LONG_MIN_RESET;
            r_cfg.max_mode           <= MAX_MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:  r_cfg.debounce_ms        <= i_cfg_data;
                CFG_SHORT_MAX: r_cfg.short_press_max_ms <= i_cfg_data;
                CFG_LONG_MIN:  r_cfg.long_press_min_ms  <= i_cfg_data;
                CFG_MAX_MODE:  r_cfg.max_mode           <= i_cfg_data[3:0];
                default:       r_cfg                    <= r_cfg;
            endcase
        end
    end

    // The front end reduces the timestamp to the counter width and turns the
    // active-low pin levels into press requests.
    bpms_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_poll  (front_poll)
    );

    // A short queue lets the front keep taking polls while the output is stalled.
    bpms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_poll  (front_poll),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_poll  (queue_poll)
    );

    // The back end holds the button and selection state, applies one poll per
    // cycle while its output is not stalled, and registers the result.
    bpms_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_poll  (queue_poll),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out)
    );

endmodule
